### rtl/core/fibt_pkg.sv
// Shared types, codes and constants of the frame interval burst tracker.
package fibt_pkg;

    localparam int TIME_W      = 64;
    localparam int VAL_W       = 20;
    localparam int TOTAL_W     = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [VAL_W-1:0] INTERVAL_CAP  = 20'd1000000;
    localparam logic [VAL_W-1:0] BURST_RESET   = 20'd4000;
    localparam logic [VAL_W-1:0] NOMINAL_RESET = 20'd16666;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_RECORD = 2'd1,
        OP_RESET  = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BURST_THRESHOLD  = 2'd0,
        CFG_NOMINAL_INTERVAL = 2'd1,
        CFG_SPARE_2          = 2'd2,
        CFG_SPARE_3          = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [3:0]        display;
        logic [TIME_W-1:0] time_us;
        logic              priority_exempt;
    } in_word_t;

    typedef struct packed {
        logic               status;
        logic               burst;
        logic [TIME_W-1:0]  last_time_us;
        logic [VAL_W-1:0]   mean_interval_us;
        logic [TOTAL_W-1:0] burst_total;
    } out_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] result;
        logic              borrow;
    } alu_rsp_t;

endpackage

### rtl/core/fibt_alu.sv
// Shared 64-bit add/subtract unit with borrow out.
module fibt_alu (
    input  fibt_pkg::alu_req_t req,
    output fibt_pkg::alu_rsp_t rsp
);
    import fibt_pkg::*;

    logic [TIME_W:0] total;

    assign total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{TIME_W{1'b0}}, req.sub};
    assign rsp   = {total[TIME_W-1:0], req.sub & ~total[TIME_W]};
endmodule

### rtl/core/fibt_ring.sv
// Interval history memory: one write port, one registered read port.
module fibt_ring #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [fibt_pkg::VAL_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [fibt_pkg::VAL_W-1:0] rd_data
);
    import fibt_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### rtl/core/frame_interval_burst_tracker.sv
// Top level of the frame interval burst tracker: sequencer, display records and config.
//
// One word at a time. A check request passes the gap and compare states; a reset, an unused
// operation code, a word for an invalid display or a record that stores no interval passes
// only the gap state. A record that stores an interval passes the gap and compare states,
// a sum pass and a divide: the ring is read one entry per cycle through its single read port
// and summed on the shared 64-bit add/subtract unit, which then performs the restoring
// divide of 20 + clog2(HISTORY+1) steps by the fill count. The input is taken again as
// soon as the result is in the output register; the history memory needs no clearing pass.
module frame_interval_burst_tracker #(
    parameter int DISPLAYS = 4,
    parameter int HISTORY  = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fibt_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output fibt_pkg::out_word_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fibt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fibt_pkg::VAL_W-1:0]       cfg_data
);
    import fibt_pkg::*;

    localparam int DISP_W = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;
    localparam int POS_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int FILL_W = $clog2(HISTORY + 1);
    localparam int SUM_W  = VAL_W + $clog2(HISTORY + 1);
    localparam int CNT_W  = $clog2(SUM_W);
    localparam int RING_D = DISPLAYS * HISTORY;
    localparam int RA_W   = (RING_D > 1) ? $clog2(RING_D) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GAP  = 6'b000010,
        S_CMP  = 6'b000100,
        S_SUM  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  last_reg [DISPLAYS];
    logic [TIME_W-1:0]  last_next [DISPLAYS];
    logic [POS_W-1:0]   wpos_reg [DISPLAYS];
    logic [POS_W-1:0]   wpos_next [DISPLAYS];
    logic [FILL_W-1:0]  fill_reg [DISPLAYS];
    logic [FILL_W-1:0]  fill_next [DISPLAYS];
    logic [VAL_W-1:0]   avg_reg [DISPLAYS];
    logic [VAL_W-1:0]   avg_next [DISPLAYS];
    logic [TOTAL_W-1:0] bcnt_reg [DISPLAYS];
    logic [TOTAL_W-1:0] bcnt_next [DISPLAYS];

    in_word_t           req_reg, req_next;
    logic [TIME_W-1:0]  gap_reg, gap_next;
    logic               first_reg, first_next;
    logic               burst_reg, burst_next;
    logic [FILL_W-1:0]  idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [FILL_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]   num_reg, num_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]   thr_reg, thr_next;
    logic [VAL_W-1:0]   nom_reg, nom_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_data_reg, out_data_next;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    logic               dvalid;
    logic [DISP_W-1:0]  d_sel;
    logic [FILL_W:0]    trial;
    logic [SUM_W-1:0]   quot;
    logic               issue;
    out_word_t          res_word;

    logic               ring_wr_en;
    logic [RA_W-1:0]    ring_wr_addr;
    logic [VAL_W-1:0]   ring_wr_data;
    logic               ring_rd_en;
    logic [RA_W-1:0]    ring_rd_addr;
    logic [VAL_W-1:0]   ring_rd_data;

    fibt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fibt_ring #(
        .DEPTH  (RING_D),
        .ADDR_W (RA_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    assign dvalid = ({1'b0, req_reg.display} < 5'(DISPLAYS));
    assign d_sel  = req_reg.display[DISP_W-1:0];
    assign trial  = {rem_reg, num_reg[SUM_W-1]};
    assign quot   = {num_reg[SUM_W-2:0], ~alu_rsp.borrow};
    assign issue  = (idx_reg < fill_reg[d_sel]);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (dvalid)
        begin
            res_word.status           = 1'b0;
            res_word.burst            = burst_reg;
            res_word.last_time_us     = last_reg[d_sel];
            res_word.mean_interval_us = avg_reg[d_sel];
            res_word.burst_total      = bcnt_reg[d_sel];
        end
        else
        begin
            res_word.status           = 1'b1;
            res_word.burst            = 1'b0;
            res_word.last_time_us     = '0;
            res_word.mean_interval_us = nom_reg;
            res_word.burst_total      = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        avg_next       = avg_reg;
        bcnt_next      = bcnt_reg;
        req_next       = req_reg;
        gap_next       = gap_reg;
        first_next     = first_reg;
        burst_next     = burst_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        thr_next       = thr_reg;
        nom_next       = nom_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        alu_req.a   = req_reg.time_us;
        alu_req.b   = last_reg[d_sel];
        alu_req.sub = 1'b1;

        ring_wr_en   = 1'b0;
        ring_wr_addr = RA_W'(int'(d_sel) * HISTORY + int'(wpos_reg[d_sel]));
        ring_wr_data = alu_rsp.borrow ? gap_reg[VAL_W-1:0] : INTERVAL_CAP;
        ring_rd_en   = 1'b0;
        ring_rd_addr = RA_W'(int'(d_sel) * HISTORY + int'(idx_reg));

        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BURST_THRESHOLD:  thr_next = cfg_data;
                CFG_NOMINAL_INTERVAL: nom_next = cfg_data;
                default:              ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    burst_next = 1'b0;
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                priority if (op_t'(req_reg.operation) == OP_RESET)
                begin
                    for (int i = 0; i < DISPLAYS; i++)
                    begin
                        last_next[i] = '0;
                        wpos_next[i] = '0;
                        fill_next[i] = '0;
                        avg_next[i]  = nom_reg;
                        bcnt_next[i] = '0;
                    end
                    state_next = S_DONE;
                end
                else if (!dvalid)
                begin
                    state_next = S_DONE;
                end
                else if (op_t'(req_reg.operation) == OP_CHECK)
                begin
                    gap_next   = alu_rsp.borrow ? '0 : alu_rsp.result;
                    first_next = (last_reg[d_sel] == '0);
                    state_next = S_CMP;
                end
                else if (op_t'(req_reg.operation) == OP_RECORD)
                begin
                    if ((last_reg[d_sel] != '0) && !alu_rsp.borrow && (alu_rsp.result != '0))
                    begin
                        gap_next   = alu_rsp.result;
                        state_next = S_CMP;
                    end
                    else
                    begin
                        last_next[d_sel] = req_reg.time_us;
                        state_next       = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                alu_req.a = gap_reg;
                if (op_t'(req_reg.operation) == OP_CHECK)
                begin
                    alu_req.b = TIME_W'(thr_reg);
                    if (!first_reg && alu_rsp.borrow && !req_reg.priority_exempt)
                    begin
                        burst_next       = 1'b1;
                        bcnt_next[d_sel] = bcnt_reg[d_sel] + 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    // clamp to one second on the way into the ring
                    alu_req.b  = TIME_W'(INTERVAL_CAP);
                    ring_wr_en = 1'b1;
                    wpos_next[d_sel] = (wpos_reg[d_sel] == POS_W'(HISTORY - 1)) ? '0
                                       : POS_W'(wpos_reg[d_sel] + 1'b1);
                    if (fill_reg[d_sel] != FILL_W'(HISTORY))
                    begin
                        fill_next[d_sel] = FILL_W'(fill_reg[d_sel] + 1'b1);
                    end
                    last_next[d_sel] = req_reg.time_us;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    acc_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                alu_req.a   = TIME_W'(acc_reg);
                alu_req.b   = TIME_W'(ring_rd_data);
                alu_req.sub = 1'b0;
                ring_rd_en  = issue;
                if (pend_reg)
                begin
                    acc_next = alu_rsp.result[SUM_W-1:0];
                end
                pend_next = issue;
                if (issue)
                begin
                    idx_next = FILL_W'(idx_reg + 1'b1);
                end
                if (!issue && !pend_reg)
                begin
                    num_next   = acc_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                alu_req.a = TIME_W'(trial);
                alu_req.b = TIME_W'(fill_reg[d_sel]);
                rem_next  = alu_rsp.borrow ? trial[FILL_W-1:0] : alu_rsp.result[FILL_W-1:0];
                num_next  = quot;
                cnt_next  = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    avg_next[d_sel] = quot[VAL_W-1:0];
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_word;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            burst_reg     <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            thr_reg       <= BURST_RESET;
            nom_reg       <= NOMINAL_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DISPLAYS; i++)
            begin
                last_reg[i] <= '0;
                wpos_reg[i] <= '0;
                fill_reg[i] <= '0;
                avg_reg[i]  <= NOMINAL_RESET;
                bcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            burst_reg     <= burst_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            thr_reg       <= thr_next;
            nom_reg       <= nom_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            avg_reg       <= avg_next;
            bcnt_reg      <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        gap_reg      <= gap_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        out_data_reg <= out_data_next;
    end
endmodule

### rtl/core/fibt_checker.sv
// Port-level assertions for the frame interval burst tracker, bound to the top level.
module fibt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input fibt_pkg::out_word_t out_data
);
    import fibt_pkg::*;

    // a result word waiting on the output holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // one word at a time: busy straight after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while busy");

    // a fresh result only appears as the sequencer returns to idle
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while still busy");

    // invalid display reports empty record
    a_invalid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> !out_data.burst && (out_data.last_time_us == '0)
            && (out_data.burst_total == '0))
        else $error("invalid display word carries record data");
endmodule

bind frame_interval_burst_tracker fibt_checker u_fibt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### tb/frame_interval_burst_tracker_tb.sv
// Self-checking testbench for the frame interval burst tracker with a display record model.
module frame_interval_burst_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fibt_pkg::*;

    localparam int DISPLAYS = 4;
    localparam int HISTORY  = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_word_t               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_BURST_THRESHOLD;
    logic [VAL_W-1:0]       cfg_data = '0;

    // tracker state as seen from outside
    logic [VAL_W-1:0]       threshold_cfg = BURST_RESET;
    logic [VAL_W-1:0]       nominal_cfg = NOMINAL_RESET;
    logic [TIME_W-1:0]      tracked_last [DISPLAYS];
    logic [VAL_W-1:0]       interval_hist [DISPLAYS][HISTORY];
    int                     hist_pos [DISPLAYS];
    int                     hist_fill [DISPLAYS];
    logic [VAL_W-1:0]       tracked_avg [DISPLAYS];
    logic [TOTAL_W-1:0]     tracked_bursts [DISPLAYS];

    out_word_t              reports_due [$];
    int                     mismatch_count = 0;
    bit                     idling_on = 1'b1;
    int                     rx_hold_request = 0;
    int                     rx_hold_left = 0;
    int                     rx_stall = 0;

    frame_interval_burst_tracker #(
        .DISPLAYS (DISPLAYS),
        .HISTORY  (HISTORY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void clear_tracked(input logic [VAL_W-1:0] avg);
        for (int d = 0; d < DISPLAYS; d++)
        begin
            tracked_last[d] = '0;
            hist_pos[d] = 0;
            hist_fill[d] = 0;
            tracked_avg[d] = avg;
            tracked_bursts[d] = '0;
        end
    endfunction

    function automatic out_word_t next_display_report(input in_word_t w);
        out_word_t          r;
        logic [3:0]         d;
        logic               known;
        logic [TIME_W-1:0]  gap;
        logic [31:0]        sum;
        r = '0;
        d = w.display;
        known = (d < DISPLAYS);
        case (op_t'(w.operation))
            OP_RESET:
                clear_tracked(nominal_cfg);
            OP_CHECK:
                if (known && tracked_last[d] != '0)
                begin
                    gap = (w.time_us >= tracked_last[d]) ? w.time_us - tracked_last[d] : '0;
                    if (gap < threshold_cfg && !w.priority_exempt)
                    begin
                        tracked_bursts[d] = tracked_bursts[d] + 1'b1;
                        r.burst = 1'b1;
                    end
                end
            OP_RECORD:
                if (known)
                begin
                    if (tracked_last[d] != '0 && w.time_us > tracked_last[d])
                    begin
                        gap = w.time_us - tracked_last[d];
                        if (gap > INTERVAL_CAP)
                            gap = INTERVAL_CAP;
                        interval_hist[d][hist_pos[d]] = gap[VAL_W-1:0];
                        hist_pos[d] = (hist_pos[d] + 1) % HISTORY;
                        if (hist_fill[d] < HISTORY)
                            hist_fill[d]++;
                        sum = '0;
                        for (int i = 0; i < hist_fill[d]; i++)
                            sum += interval_hist[d][i];
                        tracked_avg[d] = VAL_W'(sum / hist_fill[d]);
                    end
                    tracked_last[d] = w.time_us;
                end
            default:
                ;
        endcase
        if (known)
        begin
            r.status = 1'b0;
            r.last_time_us = tracked_last[d];
            r.mean_interval_us = tracked_avg[d];
            r.burst_total = tracked_bursts[d];
        end
        else
        begin
            r.status = 1'b1;
            r.burst = 1'b0;
            r.last_time_us = '0;
            r.mean_interval_us = nominal_cfg;
            r.burst_total = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            reports_due.push_back(next_display_report(in_data));
    end

    always @(posedge clk)
    begin : check_results
        out_word_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
                report_mismatch("result word with nothing outstanding");
            else
            begin
                due = reports_due.pop_front();
                check_field("status", 64'(out_data.status), 64'(due.status));
                check_field("burst", 64'(out_data.burst), 64'(due.burst));
                check_field("last_time_us", out_data.last_time_us, due.last_time_us);
                check_field("mean_interval_us", 64'(out_data.mean_interval_us),
                            64'(due.mean_interval_us));
                check_field("burst_total", 64'(out_data.burst_total), 64'(due.burst_total));
            end
        end
    end

    // receiver: long hold on request, otherwise short random stalls while idling is on
    always @(posedge clk)
    begin
        if (rx_hold_request != 0)
        begin
            rx_hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_stall != 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            rx_stall = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // leaves in_valid high so that back-to-back words need no lowering
    task automatic send_word(input op_t op, input logic [3:0] disp,
                             input logic [TIME_W-1:0] stamp, input logic exempt);
        in_word_t w;
        int       gap;
        w.operation = op;
        w.display = disp;
        w.time_us = stamp;
        w.priority_exempt = exempt;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_due.size() != 0);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [VAL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_BURST_THRESHOLD:  threshold_cfg = value;
            CFG_NOMINAL_INTERVAL: nominal_cfg = value;
            default:              ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_word();
        int                 pick;
        op_t                op;
        logic [3:0]         disp;
        logic [TIME_W-1:0]  base;
        logic [TIME_W-1:0]  stamp;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op = OP_RESET;
        else if (pick < 6)
            op = OP_UNUSED;
        else if (pick < 50)
            op = OP_CHECK;
        else
            op = OP_RECORD;
        if ($urandom_range(0, 9) == 0)
            disp = 4'($urandom_range(DISPLAYS, 15));
        else
            disp = 4'($urandom_range(0, DISPLAYS - 1));
        base = (disp < DISPLAYS) ? tracked_last[disp] : {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 55)
            stamp = base + $urandom_range(0, 2 * threshold_cfg + 100);
        else if (pick < 70)
            stamp = base + $urandom_range(0, 1500000);
        else if (pick < 80)
            stamp = base - $urandom_range(1, 5000);
        else if (pick < 85)
            stamp = base;
        else if (pick < 92)
            stamp = {$urandom, $urandom};
        else if (pick < 96)
            stamp = '0;
        else
            stamp = '1 - $urandom_range(0, 3);
        send_word(op, disp, stamp, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_reset_state();
        send_word(OP_UNUSED, 4'd0, '0, 1'b0);
        send_word(OP_CHECK, 4'd0, 64'd100, 1'b0);
        send_word(OP_CHECK, 4'd15, '1, 1'b1);
        send_word(OP_RECORD, 4'd4, 64'd5000, 1'b0);
        drain_results();
    endtask

    task automatic test_directed_cases();
        send_word(OP_RECORD, 4'd2, 64'd1000, 1'b0);
        send_word(OP_CHECK, 4'd2, 64'd2000, 1'b0);
        send_word(OP_CHECK, 4'd2, 64'd2000, 1'b1);
        send_word(OP_CHECK, 4'd2, 64'd500, 1'b0);
        send_word(OP_CHECK, 4'd2, 64'd5000, 1'b0);
        send_word(OP_CHECK, 4'd2, 64'd4999, 1'b0);
        send_word(OP_RECORD, 4'd2, 64'd21000, 1'b0);
        send_word(OP_RECORD, 4'd2, 64'd2021000, 1'b0);
        send_word(OP_RECORD, 4'd2, 64'd2021000, 1'b0);
        send_word(OP_RECORD, 4'd2, 64'd7, 1'b0);
        send_word(OP_RECORD, 4'd2, '1, 1'b0);
        send_word(OP_CHECK, 4'd2, '1, 1'b0);
        send_word(OP_RECORD, 4'd3, '0, 1'b0);
        send_word(OP_CHECK, 4'd3, '0, 1'b0);
        send_word(OP_RESET, 4'd1, 64'd12345, 1'b0);
        send_word(OP_UNUSED, 4'd2, '0, 1'b1);
        send_word(OP_RESET, 4'd9, '0, 1'b0);
        send_word(OP_UNUSED, 4'd15, '1, 1'b1);
        drain_results();
    endtask

    task automatic exercise_setting(input logic [VAL_W-1:0] thr, input logic [VAL_W-1:0] nom);
        drain_results();
        write_register(CFG_BURST_THRESHOLD, thr);
        write_register(CFG_NOMINAL_INTERVAL, nom);
        send_word(OP_RESET, 4'd0, '0, 1'b0);
        send_word(OP_UNUSED, 4'd12, '0, 1'b0);
        send_word(OP_RECORD, 4'd0, 64'd10, 1'b0);
        send_word(OP_CHECK, 4'd0, 64'd9 + thr, 1'b0);
        send_word(OP_CHECK, 4'd0, 64'd10 + thr, 1'b0);
        send_word(OP_RECORD, 4'd0, 64'd10 + thr, 1'b0);
        drain_results();
    endtask

    task automatic test_register_extremes();
        exercise_setting('0, '0);
        exercise_setting(INTERVAL_CAP, INTERVAL_CAP);
        exercise_setting(20'd1, 20'd1);
        write_register(CFG_SPARE_2, '1);
        write_register(CFG_SPARE_3, '1);
        exercise_setting(BURST_RESET, NOMINAL_RESET);
    endtask

    task automatic test_output_backpressure();
        drain_results();
        rx_hold_request = 300;
        repeat (10) send_random_word();
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [VAL_W-1:0] thr;
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_results();
            idling_on = (phase != 3);
            case (phase)
                0:       thr = BURST_RESET;
                2:       thr = INTERVAL_CAP;
                default: thr = VAL_W'($urandom_range(0, 20000));
            endcase
            write_register(CFG_BURST_THRESHOLD, thr);
            write_register(CFG_NOMINAL_INTERVAL, VAL_W'($urandom_range(0, 1000000)));
            repeat (120) send_random_word();
        end
    endtask

    initial
    begin
        clear_tracked(NOMINAL_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();
        drain_results();
        repeat (60) @(posedge clk);
        if (reports_due.size() != 0)
            report_mismatch("results still outstanding at end");
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
